[src/lbth_pkg.sv]
package lbth_pkg;

   localparam int TABLE_SLOTS_DEF = 128;
   localparam int BLOCK_BITS_DEF = 20;
   localparam int ENTRY_COUNT_BITS = 8;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_MOVE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_ABSENT  = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_PRESENT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_UPDATE,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic search;
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

[src/lbth_if.sv]
interface lbth_req_if #(
   parameter int BLOCK_BITS = lbth_pkg::BLOCK_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            operation;
   logic [BLOCK_BITS-1:0] block_number;

   modport source (output valid, output operation, output block_number, input ready);
   modport sink (input valid, input operation, input block_number, output ready);
endinterface

interface lbth_rsp_if #(
   parameter int BLOCK_BITS = lbth_pkg::BLOCK_BITS_DEF
);
   logic                                  valid;
   logic                                  ready;
   logic                                  hit;
   logic [1:0]                            status;
   logic [lbth_pkg::ENTRY_COUNT_BITS-1:0] entry_count;
   logic [BLOCK_BITS-1:0]                 oldest_block;
   logic                                  oldest_valid;

   modport source (output valid, output hit, output status, output entry_count,
                   output oldest_block, output oldest_valid, input ready);
   modport sink (input valid, input hit, input status, input entry_count,
                 input oldest_block, input oldest_valid, output ready);
endinterface

[src/lbth_cell.sv]
module lbth_cell #(
   parameter int BLOCK_BITS = lbth_pkg::BLOCK_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lbth_pkg::cell_ctrl_type ctrl,
   input  logic [BLOCK_BITS-1:0]   key,
   input  logic                    newer_valid,
   input  logic [BLOCK_BITS-1:0]   newer_block,
   output logic                    valid,
   output logic [BLOCK_BITS-1:0]   block,
   output logic                    match
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [BLOCK_BITS-1:0] block_ff;
   logic [BLOCK_BITS-1:0] block_in;
   logic                  match_ff;
   logic                  match_in;

   // load wins over shift: the newest position takes the key
   always_comb begin
      valid_in = valid_ff;
      block_in = block_ff;
      if (ctrl.load) begin
         valid_in = 1'b1;
         block_in = key;
      end else if (ctrl.shift) begin
         valid_in = newer_valid;
         block_in = newer_block;
      end
   end

   assign match_in = ctrl.search ? (valid_ff && (block_ff == key)) : match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
   end

   assign valid = valid_ff;
   assign block = block_ff;
   assign match = match_ff;

endmodule

[src/lbth_prefix.sv]
module lbth_prefix #(
   parameter int WIDTH = lbth_pkg::TABLE_SLOTS_DEF
) (
   input  logic [WIDTH-1:0] hits,
   output logic [WIDTH-1:0] covered
);

   localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic [WIDTH-1:0] lvl [0:LEVELS];

   assign lvl[0] = hits;

   // log-depth or-scan toward the newer end
   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      assign lvl[l+1] = lvl[l] | (lvl[l] << (1 << l));
   end

   assign covered = lvl[LEVELS];

endmodule

[src/lru_block_tracker_hash_core.sv]
// a request passes through the search, update and reply states; reply waits until the response side is free
// a new request is taken only in idle, after the response beat of the last one has been registered
// the row of cells is searched in parallel, removal shifts every newer cell by one
// a response beat may wait in the output register while the next request is taken
// reset (synchronous, active high) empties all cells and the count; no clearing pass
module lru_block_tracker_hash_core #(
   parameter int TABLE_SLOTS = lbth_pkg::TABLE_SLOTS_DEF,
   parameter int BLOCK_BITS = lbth_pkg::BLOCK_BITS_DEF
) (
   input logic clock,
   input logic reset,
   lbth_req_if.sink   req_bus,
   lbth_rsp_if.source rsp_bus
);

   localparam int COUNT_BITS = $clog2(TABLE_SLOTS + 1);

   lbth_pkg::state_type   state_ff;
   lbth_pkg::state_type   state_in;
   lbth_pkg::op_type      op_ff;
   lbth_pkg::op_type      op_in;
   logic [BLOCK_BITS-1:0] key_ff;
   logic [BLOCK_BITS-1:0] key_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  hit_ff;
   logic                  hit_in;
   lbth_pkg::status_type  status_ff;
   lbth_pkg::status_type  status_in;

   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   logic                                  rsp_hit_ff;
   logic                                  rsp_hit_in;
   logic [1:0]                            rsp_status_ff;
   logic [1:0]                            rsp_status_in;
   logic [lbth_pkg::ENTRY_COUNT_BITS-1:0] rsp_count_ff;
   logic [lbth_pkg::ENTRY_COUNT_BITS-1:0] rsp_count_in;
   logic [BLOCK_BITS-1:0]                 rsp_oldest_ff;
   logic [BLOCK_BITS-1:0]                 rsp_oldest_in;
   logic                                  rsp_oldest_valid_ff;
   logic                                  rsp_oldest_valid_in;

   logic                  search_all;
   logic                  do_shift;
   logic                  do_load;
   logic                  reply_free;
   logic                  any_match;
   logic                  table_full;
   logic [COUNT_BITS-1:0] load_pos;

   logic [TABLE_SLOTS-1:0] match_vec;
   logic [TABLE_SLOTS-1:0] valid_vec;
   logic [TABLE_SLOTS-1:0] covered;
   logic [BLOCK_BITS-1:0]  block_arr [TABLE_SLOTS];

   assign any_match  = |match_vec;
   assign table_full = (count_ff == COUNT_BITS'(TABLE_SLOTS));
   assign reply_free = !rsp_valid_ff || rsp_bus.ready;
   assign load_pos   = (op_ff == lbth_pkg::OP_MOVE) ? (count_ff - COUNT_BITS'(1)) : count_ff;

   lbth_prefix #(
      .WIDTH(TABLE_SLOTS)
   ) u_prefix (
      .hits   (match_vec),
      .covered(covered)
   );

   for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
      localparam logic [COUNT_BITS-1:0] CELL_POS = COUNT_BITS'(i);
      lbth_pkg::cell_ctrl_type ctrl;
      logic                    nb_valid;
      logic [BLOCK_BITS-1:0]   nb_block;

      assign ctrl.search = search_all;
      assign ctrl.shift  = do_shift && covered[i];
      assign ctrl.load   = do_load && (load_pos == CELL_POS);

      if (i == TABLE_SLOTS - 1) begin : g_last
         assign nb_valid = 1'b0;
         assign nb_block = '0;
      end else begin : g_inner
         assign nb_valid = valid_vec[i+1];
         assign nb_block = block_arr[i+1];
      end

      lbth_cell #(
         .BLOCK_BITS(BLOCK_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .key        (key_ff),
         .newer_valid(nb_valid),
         .newer_block(nb_block),
         .valid      (valid_vec[i]),
         .block      (block_arr[i]),
         .match      (match_vec[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lbth_pkg::S_IDLE: begin
            if (req_bus.valid) begin
               state_in = lbth_pkg::S_SEARCH;
            end
         end
         lbth_pkg::S_SEARCH: begin
            state_in = lbth_pkg::S_UPDATE;
         end
         lbth_pkg::S_UPDATE: begin
            state_in = lbth_pkg::S_REPLY;
         end
         lbth_pkg::S_REPLY: begin
            if (reply_free) begin
               state_in = lbth_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lbth_pkg::S_IDLE;
         end
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_bus.ready       = 1'b0;
      search_all          = 1'b0;
      do_shift            = 1'b0;
      do_load             = 1'b0;
      op_in               = op_ff;
      key_in              = key_ff;
      count_in            = count_ff;
      hit_in              = hit_ff;
      status_in           = status_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_bus.ready;
      rsp_hit_in          = rsp_hit_ff;
      rsp_status_in       = rsp_status_ff;
      rsp_count_in        = rsp_count_ff;
      rsp_oldest_in       = rsp_oldest_ff;
      rsp_oldest_valid_in = rsp_oldest_valid_ff;
      case (state_ff)
         lbth_pkg::S_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               op_in  = lbth_pkg::op_type'(req_bus.operation);
               key_in = req_bus.block_number;
            end
         end
         lbth_pkg::S_SEARCH: begin
            search_all = 1'b1;
         end
         lbth_pkg::S_UPDATE: begin
            hit_in = any_match;
            case (op_ff)
               lbth_pkg::OP_LOOKUP: begin
                  status_in = any_match ? lbth_pkg::STAT_DONE : lbth_pkg::STAT_ABSENT;
               end
               lbth_pkg::OP_INSERT: begin
                  if (any_match) begin
                     status_in = lbth_pkg::STAT_PRESENT;
                  end else if (table_full) begin
                     status_in = lbth_pkg::STAT_FULL;
                  end else begin
                     status_in = lbth_pkg::STAT_DONE;
                     do_load   = 1'b1;
                     count_in  = count_ff + COUNT_BITS'(1);
                  end
               end
               lbth_pkg::OP_REMOVE: begin
                  if (any_match) begin
                     status_in = lbth_pkg::STAT_DONE;
                     do_shift  = 1'b1;
                     count_in  = count_ff - COUNT_BITS'(1);
                  end else begin
                     status_in = lbth_pkg::STAT_ABSENT;
                  end
               end
               lbth_pkg::OP_MOVE: begin
                  if (any_match) begin
                     status_in = lbth_pkg::STAT_DONE;
                     do_shift  = 1'b1;
                     do_load   = 1'b1;
                  end else begin
                     status_in = lbth_pkg::STAT_ABSENT;
                  end
               end
               default: begin
                  status_in = lbth_pkg::STAT_ABSENT;
               end
            endcase
         end
         lbth_pkg::S_REPLY: begin
            if (reply_free) begin
               rsp_valid_in        = 1'b1;
               rsp_hit_in          = hit_ff;
               rsp_status_in       = status_ff;
               rsp_count_in        = lbth_pkg::ENTRY_COUNT_BITS'(count_ff);
               rsp_oldest_in       = valid_vec[0] ? block_arr[0] : '0;
               rsp_oldest_valid_in = valid_vec[0];
            end
         end
         default: begin
            req_bus.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbth_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff               <= op_in;
      key_ff              <= key_in;
      hit_ff              <= hit_in;
      status_ff           <= status_in;
      rsp_hit_ff          <= rsp_hit_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_count_ff        <= rsp_count_in;
      rsp_oldest_ff       <= rsp_oldest_in;
      rsp_oldest_valid_ff <= rsp_oldest_valid_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.hit          = rsp_hit_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.entry_count  = rsp_count_ff;
   assign rsp_bus.oldest_block = rsp_oldest_ff;
   assign rsp_bus.oldest_valid = rsp_oldest_valid_ff;

`ifndef ASSERT_OFF
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lbth_pkg::S_UPDATE) |-> $onehot0(match_vec))
      else $error("block held in more than one cell");

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("entry count disagrees with occupied cells");

   a_cells_packed: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, valid_vec} + (TABLE_SLOTS + 1)'(1)))
      else $error("occupied cells are not packed at the oldest end");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lbth_pkg::S_UPDATE && op_ff == lbth_pkg::OP_INSERT && do_load)
      |=> (count_ff == $past(count_ff) + COUNT_BITS'(1)))
      else $error("insert did not grow the entry count");
`endif

endmodule
